FILE: rtl/scp_pkg.sv
`default_nettype none
package scp_pkg;

  localparam int ROT_STEPS_DEF = 16;
  localparam int TABLE_LEN     = 24;

  localparam int IN_W    = 16;
  localparam int ABS_W   = IN_W + 1;
  localparam int DZ_W    = 15;
  localparam int ANG_W   = 9;
  localparam int MAG_W   = 16;
  localparam int CODE_W  = 31;
  localparam int SQ_W    = 2 * ABS_W;
  localparam int REM_W   = 32;
  localparam int PRE_SH  = 24;
  localparam int AB_W    = ABS_W + PRE_SH + 3;
  localparam int FRAC    = 16;
  localparam int Z_W     = 27;
  localparam int ATAN_W  = 22;

  // stage that forms the squares, stage that sums them, first root stage
  localparam int SQ_STAGE   = 1;
  localparam int SUM_STAGE  = 2;
  localparam int ROOT_FIRST = 3;
  localparam int ROOT_LAST  = ROOT_FIRST + MAG_W - 1;

  localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90);
  localparam logic [ANG_W-1:0] ANG_270 = ANG_W'(270);
  localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360);

  localparam logic signed [Z_W-1:0] Z_BASE_180 = Z_W'(180 << FRAC);
  localparam logic signed [Z_W-1:0] Z_BASE_360 = Z_W'(360 << FRAC);
  localparam logic signed [Z_W-1:0] Z_HALF     = Z_W'(1 << (FRAC - 1));

  // atan(2^-i) in degrees, 16 fraction bits
  localparam logic [ATAN_W-1:0] ATAN_TBL [TABLE_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic signed [IN_W-1:0] stick_x;
    logic signed [IN_W-1:0] stick_y;
  } scp_in_t;

  typedef struct packed {
    logic [ANG_W-1:0]  angle_degrees;
    logic [MAG_W-1:0]  magnitude;
    logic [CODE_W-1:0] packed_code;
  } scp_out_t;

  typedef struct packed {
    logic                   dz;
    logic                   yzero;
    logic                   xneg;
    logic signed [AB_W-1:0] a;
    logic signed [AB_W-1:0] b;
    logic signed [Z_W-1:0]  z;
    logic [ABS_W-1:0]       ax;
    logic [ABS_W-1:0]       ay;
    logic [SQ_W-1:0]        sqx;
    logic [SQ_W-1:0]        sqy;
    logic [REM_W-1:0]       rem;
    logic [MAG_W-1:0]       root;
  } scp_stage_t;

endpackage
`default_nettype wire

FILE: rtl/stick_cartesian_to_polar.sv
// Joystick sample to polar form: angle, magnitude and packed code.
// Pipeline: entry register, then scp_stage stages (the first ROTATION_STEPS each do one CORDIC
// iteration; stage 1 squares, stage 2 sums, stages 3 to 18 form one root bit each), then an output register.
// Throughput: one beat per cycle; a stall holds full stages in place while bubbles close up.
// Reset: valid bits cleared, dead_zone reset to 0.
`default_nettype none
module stick_cartesian_to_polar #(
  parameter int ROTATION_STEPS = scp_pkg::ROT_STEPS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire scp_pkg::scp_in_t in_data,
  output logic                  out_valid,
  input  wire                   out_ready,
  output scp_pkg::scp_out_t     out_data,
  input  wire                   cfg_psel,
  input  wire                   cfg_penable,
  input  wire                   cfg_pwrite,
  input  wire  [2:0]            cfg_paddr,
  input  wire  [31:0]           cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import scp_pkg::*;

  localparam int LAST = (ROTATION_STEPS > ROOT_LAST) ? ROTATION_STEPS : ROOT_LAST;

  logic [DZ_W-1:0] dead_zone_r;
  logic            cfg_wr;

  logic [LAST+1:0] rdy;
  logic [LAST:0]   stg_v;
  scp_stage_t      stg_d [LAST+1];

  scp_stage_t             s0_nxt;
  scp_stage_t             s0_r;
  logic                   s0_valid_r;
  logic signed [ABS_W-1:0] sx;
  logic signed [ABS_W-1:0] sy;
  logic signed [ABS_W-1:0] a0;
  logic signed [ABS_W-1:0] b0;

  logic                   out_valid_r;
  scp_out_t               out_data_r;
  scp_out_t               out_nxt;
  logic signed [Z_W-1:0]  z_rnd;
  logic [Z_W-FRAC-1:0]    deg_full;
  logic [ANG_W-1:0]       ang;
  logic [MAG_W-1:0]       mag;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {(32 - DZ_W)'(0), dead_zone_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= '0;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      dead_zone_r <= cfg_pwdata[DZ_W-1:0];
    end
  end

  // ready ripples back from the output register
  always_comb begin
    rdy[LAST+1] = !out_valid_r || out_ready;
    for (int k = LAST; k >= 0; k--) begin
      rdy[k] = !stg_v[k] || rdy[k+1];
    end
  end
  assign in_ready = rdy[0];

  // entry stage
  always_comb begin
    sx = ABS_W'(in_data.stick_x);
    sy = ABS_W'(in_data.stick_y);
    s0_nxt       = '0;
    s0_nxt.ax    = sx[ABS_W-1] ? ABS_W'(-sx) : ABS_W'(sx);
    s0_nxt.ay    = sy[ABS_W-1] ? ABS_W'(-sy) : ABS_W'(sy);
    s0_nxt.dz    = ({2'b00, dead_zone_r} > s0_nxt.ax) && ({2'b00, dead_zone_r} > s0_nxt.ay);
    s0_nxt.yzero = (in_data.stick_y == '0);
    s0_nxt.xneg  = in_data.stick_x[IN_W-1];
    if (sy[ABS_W-1]) begin
      a0       = -sy;
      b0       = -sx;
      s0_nxt.z = Z_BASE_180;
    end else begin
      a0       = sy;
      b0       = sx;
      s0_nxt.z = sx[ABS_W-1] ? Z_BASE_360 : '0;
    end
    s0_nxt.a = signed'({{(AB_W - ABS_W - PRE_SH){a0[ABS_W-1]}}, a0, PRE_SH'(0)});
    s0_nxt.b = signed'({{(AB_W - ABS_W - PRE_SH){b0[ABS_W-1]}}, b0, PRE_SH'(0)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (rdy[0]) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_r <= s0_nxt;
    end
  end

  assign stg_v[0] = s0_valid_r;
  assign stg_d[0] = s0_r;

  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    scp_stage #(
      .STAGE     (k),
      .ROT_STEPS (ROTATION_STEPS)
    ) u_stage (
      .clk         (clk),
      .rst_n       (rst_n),
      .load        (rdy[k]),
      .src_valid   (stg_v[k-1]),
      .src         (stg_d[k-1]),
      .dst_valid_r (stg_v[k]),
      .dst_r       (stg_d[k])
    );
  end

  // rounding and output selection
  always_comb begin
    z_rnd    = stg_d[LAST].z + Z_HALF;
    deg_full = z_rnd[Z_W-1:FRAC];
    if (stg_d[LAST].z[Z_W-1]) begin
      ang = '0;
    end else if (deg_full > (Z_W - FRAC)'(ANG_360)) begin
      ang = ANG_360;
    end else begin
      ang = deg_full[ANG_W-1:0];
    end
    if (stg_d[LAST].yzero) begin
      ang = stg_d[LAST].xneg ? ANG_270 : ANG_90;
    end
    mag = stg_d[LAST].root
        + MAG_W'(stg_d[LAST].rem > REM_W'(stg_d[LAST].root));
    out_nxt.angle_degrees = ang;
    out_nxt.magnitude     = mag;
    out_nxt.packed_code   = {mag, (CODE_W - MAG_W - ANG_W)'(0), ang};
    if (stg_d[LAST].dz) begin
      out_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy[LAST+1]) begin
      out_valid_r <= stg_v[LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST+1]) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/scp_stage.sv
`default_nettype none
module scp_stage #(
  parameter int STAGE     = 1,
  parameter int ROT_STEPS = scp_pkg::ROT_STEPS_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      load,
  input  wire                      src_valid,
  input  wire scp_pkg::scp_stage_t src,
  output logic                     dst_valid_r,
  output scp_pkg::scp_stage_t      dst_r
);
  import scp_pkg::*;

  localparam bit DO_ROT  = (STAGE - 1) < ROT_STEPS;
  localparam int ITER    = ((STAGE - 1) < TABLE_LEN) ? (STAGE - 1) : 0;
  localparam bit DO_ROOT = (STAGE >= ROOT_FIRST) && (STAGE <= ROOT_LAST);
  localparam int RBIT    = DO_ROOT ? (ROOT_LAST - STAGE) : 0;

  scp_stage_t          dst_nxt;
  logic signed [AB_W-1:0] da;
  logic signed [AB_W-1:0] db;
  logic signed [Z_W-1:0]  dz_ang;
  logic [REM_W+1:0]       trial;

  always_comb begin
    dst_nxt = src;
    da      = src.b >>> ITER;
    db      = src.a >>> ITER;
    dz_ang  = signed'({(Z_W - ATAN_W)'(0), ATAN_TBL[ITER]});
    trial   = ((REM_W + 2)'(src.root) << (RBIT + 1)) + ((REM_W + 2)'(1) << (2 * RBIT));
    if (DO_ROT) begin
      if (!src.b[AB_W-1]) begin
        dst_nxt.a = src.a + da;
        dst_nxt.b = src.b - db;
        dst_nxt.z = src.z + dz_ang;
      end else begin
        dst_nxt.a = src.a - da;
        dst_nxt.b = src.b + db;
        dst_nxt.z = src.z - dz_ang;
      end
    end
    if (STAGE == SQ_STAGE) begin
      dst_nxt.sqx = SQ_W'(src.ax) * SQ_W'(src.ax);
      dst_nxt.sqy = SQ_W'(src.ay) * SQ_W'(src.ay);
    end
    if (STAGE == SUM_STAGE) begin
      dst_nxt.rem  = REM_W'(src.sqx + src.sqy);
      dst_nxt.root = '0;
    end
    if (DO_ROOT) begin
      if ({2'b00, src.rem} >= trial) begin
        dst_nxt.rem  = src.rem - trial[REM_W-1:0];
        dst_nxt.root = src.root | (MAG_W'(1) << RBIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dst_valid_r <= 1'b0;
    end else if (load) begin
      dst_valid_r <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      dst_r <= dst_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb_stick_cartesian_to_polar.sv
`timescale 1ns / 1ps

module tb_stick_cartesian_to_polar;
  import scp_pkg::*;

  localparam int ROT_STEPS = 16;
  localparam int PIPE_LAT = (ROT_STEPS > 18 ? ROT_STEPS : 18) + 1;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 220;
  localparam int NUM_PHASES = 6;
  localparam longint CYCLE_LIMIT = 600000;

  localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
  localparam logic [2:0] REG_UNMAPPED = 3'd4;

  class polar_scoreboard;
    logic [DZ_W-1:0] dead_zone;
    scp_out_t polar_expected_q[$];
    int unsigned errors;

    function new();
      dead_zone = '0;
      errors = 0;
    endfunction

    function scp_out_t predict_polar(scp_in_t s);
      longint x, y, ax, ay, a, b, z, da, db, deg, step;
      longint unsigned sq, r, t;
      scp_out_t res;
      x = s.stick_x;
      y = s.stick_y;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      res = '0;
      if (ax < longint'(dead_zone) && ay < longint'(dead_zone)) return res;
      if (y == 0) begin
        deg = (x < 0) ? 270 : 90;
      end else begin
        if (y < 0) begin
          a = -y * 64'sd16777216;
          b = -x * 64'sd16777216;
          z = 64'sd180 <<< FRAC;
        end else begin
          a = y * 64'sd16777216;
          b = x * 64'sd16777216;
          z = (x < 0) ? (64'sd360 <<< FRAC) : 0;
        end
        for (int i = 0; i < ROT_STEPS && i < TABLE_LEN; i++) begin
          da = b >>> i;
          db = a >>> i;
          step = longint'(ATAN_TBL[i]);
          if (b >= 0) begin
            a = a + da;
            b = b - db;
            z = z + step;
          end else begin
            a = a - da;
            b = b + db;
            z = z - step;
          end
        end
        if (z >= 0) deg = (z + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
        else deg = -((-z + (64'sd1 <<< (FRAC - 1))) >>> FRAC);
        if (deg < 0) deg = 0;
        if (deg > 360) deg = 360;
      end
      sq = longint'(ax * ax) + longint'(ay * ay);
      r = 0;
      for (int k = 16; k >= 0; k--) begin
        t = r | (64'd1 << k);
        if (t * t <= sq) r = t;
      end
      if (sq > r * r + r) r = r + 1;
      res.angle_degrees = deg[ANG_W-1:0];
      res.magnitude = r[MAG_W-1:0];
      t = r * 32768 + longint'(deg);
      res.packed_code = t[CODE_W-1:0];
      return res;
    endfunction

    function void note_sample(scp_in_t s);
      polar_expected_q.push_back(predict_polar(s));
    endfunction

    function void check_result(scp_out_t got);
      scp_out_t want;
      if (polar_expected_q.size() == 0) begin
        $error("result beat with no sample pending: %p", got);
        errors++;
        return;
      end
      want = polar_expected_q.pop_front();
      if (got.angle_degrees !== want.angle_degrees) begin
        $error("angle_degrees: expected %0d, got %0d", want.angle_degrees, got.angle_degrees);
        errors++;
      end
      if (got.magnitude !== want.magnitude) begin
        $error("magnitude: expected %0d, got %0d", want.magnitude, got.magnitude);
        errors++;
      end
      if (got.packed_code !== want.packed_code) begin
        $error("packed_code: expected %0d, got %0d", want.packed_code, got.packed_code);
        errors++;
      end
    endfunction

    function int pending();
      return polar_expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  scp_in_t in_data;
  logic out_valid;
  logic out_ready;
  scp_out_t out_data;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  polar_scoreboard sb;
  int unsigned tx_max;
  int unsigned rx_max;
  bit hold_req;
  longint cycle_cnt;

  stick_cartesian_to_polar #(
    .ROTATION_STEPS(ROT_STEPS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_cnt = 0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt >= CYCLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic scp_in_t mk(int x, int y);
    scp_in_t s;
    s.stick_x = x[15:0];
    s.stick_y = y[15:0];
    return s;
  endfunction

  function automatic int rand_axis(int dz);
    int pick;
    int v;
    pick = $urandom_range(0, 5);
    case (pick)
      0: v = -32768;
      1: v = 32767;
      2: v = $urandom_range(0, 6) - 3;
      3: v = int'($urandom_range(0, 2 * dz + 4)) - dz - 2;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    return v;
  endfunction

  function automatic scp_in_t rand_sample(int dz);
    int x;
    int y;
    int m;
    x = int'($urandom_range(0, 65535)) - 32768;
    y = int'($urandom_range(0, 65535)) - 32768;
    case ($urandom_range(0, 9))
      4: y = 0;
      5: x = 0;
      6: begin
        x = int'($urandom_range(0, 2 * dz + 4)) - dz - 2;
        y = int'($urandom_range(0, 2 * dz + 4)) - dz - 2;
      end
      7: begin
        x = rand_axis(dz);
        y = rand_axis(dz);
      end
      8: begin
        if ($urandom_range(0, 1)) x = int'($urandom_range(0, 6)) - 3;
        else y = int'($urandom_range(0, 6)) - 3;
      end
      9: begin
        m = $urandom_range(0, 32767);
        x = $urandom_range(0, 1) ? -m : m;
        y = $urandom_range(0, 1) ? -m : m;
      end
      default: ;
    endcase
    return mk(x, y);
  endfunction

  task automatic send_sample(input scp_in_t s);
    int unsigned gap;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_sample(s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == REG_DEAD_ZONE) sb.dead_zone = val[DZ_W-1:0];
  endtask

  task automatic set_dead_zone(input int dz);
    logic [31:0] word;
    word = $urandom;
    word[DZ_W-1:0] = dz[DZ_W-1:0];
    write_reg(REG_DEAD_ZONE, word);
  endtask

  // sink side: per-beat random stall, plus a long hold-off on request
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = $urandom_range(0, rx_max);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    scp_in_t plain_q[$];
    scp_in_t dz_q[$];
    int dz_set[NUM_PHASES];
    sb = new();
    tx_max = 19;
    rx_max = 19;
    hold_req = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // dead zone at reset value: zero vector, axes, corners, near +y
    plain_q = '{mk(0, 0), mk(32767, 0), mk(-32768, 0), mk(0, 32767), mk(0, -32768),
                mk(-32768, -32768), mk(32767, 32767), mk(32767, -32768), mk(-32768, 32767),
                mk(-1, 32767), mk(-1, 1), mk(1, -1), mk(-1, -1), mk(1, 1), mk(0, 1),
                mk(0, -1), mk(-1, 0), mk(1, 0)};
    foreach (plain_q[i]) send_sample(plain_q[i]);
    drain();

    set_dead_zone(100);
    write_reg(REG_UNMAPPED, 32'h0000_7fff);
    dz_q = '{mk(99, -99), mk(100, 0), mk(-99, 99), mk(-100, 5), mk(0, 0), mk(-99, -101)};
    foreach (dz_q[i]) send_sample(dz_q[i]);
    drain();

    dz_set[0] = 32767;
    dz_set[1] = 0;
    dz_set[2] = $urandom_range(1, 32766);
    dz_set[3] = 1;
    dz_set[4] = 2000;
    dz_set[5] = $urandom_range(0, 300);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_dead_zone(dz_set[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) begin
          tx_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
          rx_max = ($urandom_range(0, 3) == 0) ? 0 : 19;
          if (p == 2 && n == 0) begin
            tx_max = 0;
            hold_req = 1'b1;
          end
        end
        if (p == 4 && n == 110) drain();
        send_sample(rand_sample(dz_set[p]));
      end
      drain();
    end

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
